@@ rtl/core/ps2hcq_pkg.sv @@
`default_nettype none

package ps2hcq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] ACK_CODE    = 8'hFA;
    localparam logic [7:0] RESEND_CODE = 8'hFE;

    localparam logic CFG_KBD_FIRST  = 1'b0;
    localparam logic CFG_KBD_SECOND = 1'b1;

    typedef enum logic [1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_RX_BYTE = 2'd1,
        REQ_KICK    = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KIND_SEND    = 2'd0,
        KIND_FORWARD = 2'd1,
        KIND_DROP    = 2'd2,
        KIND_TIMEOUT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CMD_IDLE      = 2'd0,
        CMD_WAIT_ACK  = 2'd1,
        CMD_WAIT_RESP = 2'd2
    } cmd_state_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RECV = 2'd1,
        S_KICK = 2'd2,
        S_OUT2 = 2'd3
    } fsm_t;

    typedef struct packed {
        logic       port;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       two;
        logic       sent;
        logic [7:0] resp;
        cmd_state_t st;
    } entry_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic       port;
        logic [7:0] data;
        logic       last;
    } result_t;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        if (i == IDX_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return i + 1'b1;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ps2hcq_ram.sv @@
`default_nettype none

module ps2hcq_ram (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic [ps2hcq_pkg::IDX_W-1:0]   waddr,
    input  wire ps2hcq_pkg::entry_t             wdata,
    input  wire logic [ps2hcq_pkg::IDX_W-1:0]   raddr,
    output ps2hcq_pkg::entry_t                  rdata
);

    ps2hcq_pkg::entry_t mem [ps2hcq_pkg::QUEUE_DEPTH];
    ps2hcq_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/ps2hcq_seq.sv @@
`default_nettype none

module ps2hcq_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         kbd,
    input  wire logic [1:0]         req_type,
    input  wire logic               port,
    input  wire logic [7:0]         first_byte,
    input  wire logic [7:0]         second_byte,
    input  wire logic               two_bytes,
    input  wire logic [7:0]         resp_count,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               tx_blocked,
    output ps2hcq_pkg::result_t     res_next
);

    localparam int IW = ps2hcq_pkg::IDX_W;

    ps2hcq_pkg::fsm_t   state_reg, state_next;
    logic [IW-1:0]      head_reg, head_next;
    logic [IW-1:0]      tail_reg, tail_next;

    logic               rq_port_reg, rq_port_next;
    logic [7:0]         rq_rx_reg, rq_rx_next;
    logic               rq_blk_reg, rq_blk_next;

    logic               fwd_pend_reg, fwd_pend_next;
    logic               kick_pend_reg, kick_pend_next;
    ps2hcq_pkg::result_t kick_res_reg, kick_res_next;

    logic               byp_valid_reg, byp_valid_next;
    ps2hcq_pkg::entry_t byp_entry_reg, byp_entry_next;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    ps2hcq_pkg::entry_t ram_wdata;
    logic [IW-1:0]      ram_raddr;
    ps2hcq_pkg::entry_t ram_rdata;

    logic               accept;
    logic               empty;
    logic               full;
    ps2hcq_pkg::entry_t enq_entry;

    logic               rx_match;
    logic               rx_pop;
    logic               rx_fwd;
    logic [7:0]         rx_resp_dec;
    ps2hcq_pkg::entry_t rx_entry;

    ps2hcq_pkg::entry_t kick_entry;
    logic               kick_valid;
    ps2hcq_pkg::result_t kick_res;
    ps2hcq_pkg::entry_t kick_upd;

    ps2hcq_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != ps2hcq_pkg::S_IDLE);
    assign accept = start && !busy;
    assign empty  = (head_reg == tail_reg);
    assign full   = (ps2hcq_pkg::next_idx(tail_reg) == head_reg);

    always_comb
    begin
        enq_entry      = '0;
        enq_entry.port = port;
        enq_entry.b0   = first_byte;
        enq_entry.b1   = two_bytes ? second_byte : 8'h00;
        enq_entry.two  = two_bytes;
        enq_entry.sent = 1'b0;
        enq_entry.resp = resp_count;
        enq_entry.st   = ps2hcq_pkg::CMD_IDLE;
    end

    // received byte against the head entry
    always_comb
    begin
        rx_entry    = ram_rdata;
        rx_pop      = 1'b0;
        rx_fwd      = 1'b1;
        rx_resp_dec = ram_rdata.resp - 8'd1;
        rx_match    = !empty && (ram_rdata.port == rq_port_reg)
                      && (ram_rdata.st != ps2hcq_pkg::CMD_IDLE);
        if (rx_match)
        begin
            rx_fwd = 1'b0;
            if (ram_rdata.st == ps2hcq_pkg::CMD_WAIT_ACK)
            begin
                if (rq_rx_reg == ps2hcq_pkg::ACK_CODE)
                begin
                    rx_entry.sent = 1'b1;
                    if (ram_rdata.two && !ram_rdata.sent)
                    begin
                        rx_entry.st = ps2hcq_pkg::CMD_IDLE;
                    end
                    else if (ram_rdata.resp != 8'd0)
                    begin
                        rx_entry.st = ps2hcq_pkg::CMD_WAIT_RESP;
                    end
                    else
                    begin
                        rx_pop = 1'b1;
                    end
                end
                else if (rq_rx_reg == ps2hcq_pkg::RESEND_CODE)
                begin
                    rx_entry.st = ps2hcq_pkg::CMD_IDLE;
                end
            end
            else
            begin
                if (ram_rdata.resp != 8'd0)
                begin
                    rx_entry.resp = rx_resp_dec;
                end
                if (rx_entry.resp == 8'd0)
                begin
                    rx_pop = 1'b1;
                    rx_fwd = 1'b1;
                end
            end
        end
    end

    // kick of the head entry; head written last cycle comes from the bypass
    always_comb
    begin
        kick_entry    = byp_valid_reg ? byp_entry_reg : ram_rdata;
        kick_valid    = !empty && (kick_entry.st == ps2hcq_pkg::CMD_IDLE);
        kick_upd      = kick_entry;
        kick_upd.st   = ps2hcq_pkg::CMD_WAIT_ACK;
        kick_res      = '0;
        kick_res.valid = kick_valid;
        kick_res.port = kick_entry.port;
        kick_res.last = 1'b1;
        if (rq_blk_reg)
        begin
            kick_res.kind = ps2hcq_pkg::KIND_TIMEOUT;
            kick_res.data = 8'h00;
        end
        else
        begin
            kick_res.kind = ps2hcq_pkg::KIND_SEND;
            kick_res.data = kick_entry.sent ? kick_entry.b1 : kick_entry.b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ps2hcq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (ps2hcq_pkg::req_t'(req_type))
                        ps2hcq_pkg::REQ_RX_BYTE: state_next = ps2hcq_pkg::S_RECV;
                        ps2hcq_pkg::REQ_KICK:    state_next = ps2hcq_pkg::S_KICK;
                        default:                 state_next = ps2hcq_pkg::S_IDLE;
                    endcase
                end
            end
            ps2hcq_pkg::S_RECV:
            begin
                state_next = ps2hcq_pkg::S_KICK;
            end
            ps2hcq_pkg::S_KICK:
            begin
                state_next = (fwd_pend_reg && kick_valid) ? ps2hcq_pkg::S_OUT2
                                                          : ps2hcq_pkg::S_IDLE;
            end
            ps2hcq_pkg::S_OUT2:
            begin
                state_next = ps2hcq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ps2hcq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        rq_port_next   = rq_port_reg;
        rq_rx_next     = rq_rx_reg;
        rq_blk_next    = rq_blk_reg;
        fwd_pend_next  = fwd_pend_reg;
        kick_pend_next = 1'b0;
        kick_res_next  = kick_res_reg;
        byp_valid_next = 1'b0;
        byp_entry_next = byp_entry_reg;
        ram_we         = 1'b0;
        ram_waddr      = head_reg;
        ram_wdata      = rx_entry;
        ram_raddr      = head_reg;
        res_next       = '0;
        unique case (state_reg)
            ps2hcq_pkg::S_IDLE:
            begin
                fwd_pend_next = 1'b0;
                if (accept)
                begin
                    rq_port_next = port;
                    rq_rx_next   = rx_byte;
                    rq_blk_next  = tx_blocked;
                    if (ps2hcq_pkg::req_t'(req_type) == ps2hcq_pkg::REQ_ENQUEUE)
                    begin
                        if (full)
                        begin
                            res_next.valid = 1'b1;
                            res_next.kind  = ps2hcq_pkg::KIND_DROP;
                            res_next.port  = port;
                            res_next.data  = 8'h00;
                            res_next.last  = 1'b1;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = tail_reg;
                            ram_wdata = enq_entry;
                            tail_next = ps2hcq_pkg::next_idx(tail_reg);
                        end
                    end
                end
            end
            ps2hcq_pkg::S_RECV:
            begin
                ram_we         = rx_match;
                ram_waddr      = head_reg;
                ram_wdata      = rx_entry;
                head_next      = rx_pop ? ps2hcq_pkg::next_idx(head_reg) : head_reg;
                ram_raddr      = head_next;
                byp_valid_next = rx_match && !rx_pop;
                byp_entry_next = rx_entry;
                fwd_pend_next  = rx_fwd && kbd[rq_port_reg];
            end
            ps2hcq_pkg::S_KICK:
            begin
                ram_we    = kick_valid && !rq_blk_reg;
                ram_waddr = head_reg;
                ram_wdata = kick_upd;
                if (fwd_pend_reg)
                begin
                    res_next.valid = 1'b1;
                    res_next.kind  = ps2hcq_pkg::KIND_FORWARD;
                    res_next.port  = rq_port_reg;
                    res_next.data  = rq_rx_reg;
                    res_next.last  = !kick_valid;
                    kick_pend_next = kick_valid;
                    kick_res_next  = kick_res;
                end
                else
                begin
                    res_next = kick_res;
                end
            end
            ps2hcq_pkg::S_OUT2:
            begin
                res_next = kick_res_reg;
                res_next.valid = kick_pend_reg;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ps2hcq_pkg::S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fwd_pend_reg  <= 1'b0;
            kick_pend_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fwd_pend_reg  <= fwd_pend_next;
            kick_pend_reg <= kick_pend_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rq_port_reg   <= rq_port_next;
        rq_rx_reg     <= rq_rx_next;
        rq_blk_reg    <= rq_blk_next;
        kick_res_reg  <= kick_res_next;
        byp_entry_reg <= byp_entry_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/ps2_host_command_queue.sv @@
`default_nettype none

// PS/2 host command queue. A transaction is taken when start is high and busy is
// low. An enqueue leaves busy low; a full queue answers with a drop result in
// the next cycle. A kick result passes the state and result registers, a
// received byte also the S_RECV state, and a second result of the same
// transaction follows in the next cycle. Busy stays high until the last result
// is registered. The head entry is read through the queue RAM's one registered
// read port, modified and written back. Each result is shown on res_strobe for
// exactly one cycle and must be taken then. The user must make configuration
// writes only while busy is low; the block itself does not enforce this.

module ps2_host_command_queue (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic       cfg_data,
    input  wire logic [1:0] req_type,
    input  wire logic       port,
    input  wire logic [7:0] first_byte,
    input  wire logic [7:0] second_byte,
    input  wire logic       two_bytes,
    input  wire logic [7:0] resp_count,
    input  wire logic [7:0] rx_byte,
    input  wire logic       tx_blocked,
    output logic            res_strobe,
    output logic [1:0]      res_kind,
    output logic            res_port,
    output logic [7:0]      res_byte,
    output logic            last
);

    logic                kbd_first_reg;
    logic                kbd_second_reg;
    ps2hcq_pkg::result_t res_next;
    ps2hcq_pkg::result_t res_reg;

    ps2hcq_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kbd         ({kbd_second_reg, kbd_first_reg}),
        .req_type    (req_type),
        .port        (port),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .two_bytes   (two_bytes),
        .resp_count  (resp_count),
        .rx_byte     (rx_byte),
        .tx_blocked  (tx_blocked),
        .res_next    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kbd_first_reg  <= 1'b0;
            kbd_second_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ps2hcq_pkg::CFG_KBD_FIRST:  kbd_first_reg  <= cfg_data;
                ps2hcq_pkg::CFG_KBD_SECOND: kbd_second_reg <= cfg_data;
                default:                    kbd_first_reg  <= kbd_first_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res_strobe = res_reg.valid;
    assign res_kind   = res_reg.kind;
    assign res_port   = res_reg.port;
    assign res_byte   = res_reg.data;
    assign last       = res_reg.last;

`ifndef ASSERT_OFF
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && !last |=> res_strobe && last)
        else $error("non-final result not followed by final result");

    a_drop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && (res_kind == ps2hcq_pkg::KIND_DROP) |-> last && (res_byte == 8'h00))
        else $error("drop result malformed");

    a_enqueue_quick: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req_type == ps2hcq_pkg::REQ_ENQUEUE) |=> !busy)
        else $error("enqueue left block busy");

    a_kick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req_type == ps2hcq_pkg::REQ_KICK) |=> busy && !res_strobe)
        else $error("kick transaction not processed");
`endif

endmodule

`default_nettype wire
